// ===== rtl/ecr_pkg.sv =====
package ecr_pkg;

  localparam int TIMER_W    = 16;
  localparam int SCALE_W    = 16;
  localparam int RANGE_W    = 23;
  localparam int DIST_SHIFT = 9;
  localparam int NUM_CH     = 3;
  localparam int NUM_STAGES = 8;

  localparam int WINDOW_LENGTH_DEF = 10;
  localparam int COUNT_MODULUS_DEF = 65536;

  localparam int CH_HEAD  = 0;
  localparam int CH_LEFT  = 1;
  localparam int CH_RIGHT = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd348;
  localparam logic [RANGE_W-1:0] JUMP_RESET  = 23'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_PER_TICK = 2'd0,
    CFG_JUMP_LIMIT     = 2'd1
  } cfg_idx_t;

  // One load strobe per pipeline stage: high when an item moves into it.
  typedef struct packed {
    logic p1;
    logic p2;
    logic p3;
    logic p4;
    logic p5;
    logic p6;
    logic p7;
    logic p8;
  } pipe_ld_t;

endpackage

// ===== rtl/three_channel_echo_ranger.sv =====
// Channel | Direction | Transfer carries
// in_     | slave     | one pin-change event: three echo levels and the timer count
// out_    | master    | three ranges and the trigger pulse, one result per event
// cfg_    | slave     | register write: index 0 scale_per_tick, index 1 jump_limit
//
// Throughput is one event per cycle while the output is not stalled; an input transfer
// reaches out_tvalid through the eight-stage pipeline (two stages of modulo reduce,
// edge detect, ring update, reciprocal divide, correction, scale multiply, merge).
// Every per-channel recurrence (edge state, ring/sum, head range) closes within its
// own stage. Reset is synchronous and takes effect at once; the width rings
// need no clearing pass, since a fill flag per lane makes unwritten entries read zero.
// A stall on out_tready fills stages from the output back; in_tready drops
// only when every stage holds an item.
module three_channel_echo_ranger #(
  parameter int WINDOW_LENGTH = ecr_pkg::WINDOW_LENGTH_DEF,
  parameter int COUNT_MODULUS = ecr_pkg::COUNT_MODULUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // [0] head_level, [1] left_level, [2] right_level,
  // [18:3] timer_count, [23:19] zero
  input  logic [ecr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [22:0] range_head, [45:23] range_left, [68:46] range_right,
  // [69] trigger_pulse, [71:70] zero
  output logic [ecr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ecr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ecr_pkg::*;

  localparam int CW = $clog2(COUNT_MODULUS);

  logic [SCALE_W-1:0] scale_r;
  logic [RANGE_W-1:0] jump_r;

  logic [NUM_STAGES:1] v_r;
  logic [NUM_STAGES:1] v_nxt;
  logic [NUM_STAGES:1] rdy;
  logic [NUM_STAGES:1] ld_vec;
  pipe_ld_t            ld;

  logic [CW-1:0]                  now_mod;
  logic [NUM_CH-1:0]              levels;
  logic [NUM_CH-1:0]              meas_valid;
  logic [NUM_CH-1:0][RANGE_W-1:0] lane_range;
  logic [NUM_CH-1:0][RANGE_W-1:0] ranges;
  logic                           trigger_pulse;

  // Register writes; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      jump_r  <= JUMP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCALE_PER_TICK: scale_r <= cfg_data[SCALE_W-1:0];
        CFG_JUMP_LIMIT:     jump_r  <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage takes a new item when it is empty or its item advances.
  always_comb begin
    rdy[NUM_STAGES] = !v_r[NUM_STAGES] || out_tready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld_vec[1] = in_tvalid && rdy[1];
    v_nxt[1]  = rdy[1] ? in_tvalid : v_r[1];
    for (int k = 2; k <= NUM_STAGES; k++) begin
      ld_vec[k] = v_r[k-1] && rdy[k];
      v_nxt[k]  = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    ld.p1 = ld_vec[1];
    ld.p2 = ld_vec[2];
    ld.p3 = ld_vec[3];
    ld.p4 = ld_vec[4];
    ld.p5 = ld_vec[5];
    ld.p6 = ld_vec[6];
    ld.p7 = ld_vec[7];
    ld.p8 = ld_vec[8];
  end

  assign in_tready  = rdy[1];
  assign out_tvalid = v_r[NUM_STAGES];

  ecr_front #(
    .COUNT_MODULUS (COUNT_MODULUS)
  ) u_front (
    .clk         (clk),
    .ld          (ld),
    .timer_count (in_tdata[TIMER_W+NUM_CH-1:NUM_CH]),
    .echo_levels (in_tdata[NUM_CH-1:0]),
    .now_mod     (now_mod),
    .levels      (levels)
  );

  // One lane per echo channel; the lanes share the reduced timer count.
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    ecr_lane #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .COUNT_MODULUS (COUNT_MODULUS)
    ) u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .ld             (ld),
      .echo_level     (levels[ch]),
      .now_mod        (now_mod),
      .scale_per_tick (scale_r),
      .meas_valid     (meas_valid[ch]),
      .lane_range     (lane_range[ch])
    );
  end

  ecr_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld            (ld),
    .meas_valid    (meas_valid),
    .lane_range    (lane_range),
    .jump_limit    (jump_r),
    .ranges        (ranges),
    .trigger_pulse (trigger_pulse)
  );

  assign out_tdata = {2'b00, trigger_pulse, ranges[CH_RIGHT], ranges[CH_LEFT], ranges[CH_HEAD]};

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is accepting");

endmodule

// ===== rtl/ecr_front.sv =====
module ecr_front #(
  parameter int COUNT_MODULUS = ecr_pkg::COUNT_MODULUS_DEF
) (
  input  logic                                 clk,
  input  ecr_pkg::pipe_ld_t                    ld,
  input  logic [ecr_pkg::TIMER_W-1:0]          timer_count,
  input  logic [ecr_pkg::NUM_CH-1:0]           echo_levels,
  output logic [$clog2(COUNT_MODULUS)-1:0]     now_mod,
  output logic [ecr_pkg::NUM_CH-1:0]           levels
);
  import ecr_pkg::*;

  localparam int CW   = $clog2(COUNT_MODULUS);
  localparam int RT   = (2 ** TIMER_W) / COUNT_MODULUS;
  localparam int RT_W = $clog2(RT + 1);
  localparam logic [TIMER_W:0] MOD_C = (TIMER_W + 1)'(COUNT_MODULUS);
  localparam logic [RT_W-1:0]  RT_C  = RT_W'(RT);

  logic [TIMER_W-1:0]      now1_r;
  logic [NUM_CH-1:0]       lvl1_r;
  logic [RT_W-1:0]         qt1_r;
  logic [TIMER_W+RT_W-1:0] qprod;
  logic [TIMER_W:0]        rem;
  logic [TIMER_W:0]        rem_fix;
  logic [CW-1:0]           now2_r;
  logic [NUM_CH-1:0]       lvl2_r;

  // Quotient estimate by reciprocal; it is low by at most one.
  assign qprod = (TIMER_W + RT_W)'(timer_count) * (TIMER_W + RT_W)'(RT_C);

  always_comb begin
    rem     = (TIMER_W + 1)'(now1_r) - (TIMER_W + 1)'(qt1_r) * MOD_C;
    rem_fix = (rem >= MOD_C) ? rem - MOD_C : rem;
  end

  always_ff @(posedge clk) begin
    if (ld.p1) begin
      now1_r <= timer_count;
      lvl1_r <= echo_levels;
      qt1_r  <= qprod[TIMER_W+RT_W-1:TIMER_W];
    end
    if (ld.p2) begin
      now2_r <= CW'(rem_fix);
      lvl2_r <= lvl1_r;
    end
  end

  assign now_mod = now2_r;
  assign levels  = lvl2_r;

endmodule

// ===== rtl/ecr_lane.sv =====
module ecr_lane #(
  parameter int WINDOW_LENGTH = ecr_pkg::WINDOW_LENGTH_DEF,
  parameter int COUNT_MODULUS = ecr_pkg::COUNT_MODULUS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ecr_pkg::pipe_ld_t                  ld,
  input  logic                               echo_level,
  input  logic [$clog2(COUNT_MODULUS)-1:0]   now_mod,
  input  logic [ecr_pkg::SCALE_W-1:0]        scale_per_tick,
  output logic                               meas_valid,
  output logic [ecr_pkg::RANGE_W-1:0]        lane_range
);
  import ecr_pkg::*;

  localparam int CW    = $clog2(COUNT_MODULUS);
  localparam int SUM_W = $clog2(WINDOW_LENGTH * (COUNT_MODULUS - 1) + 1);
  localparam int PW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int PR_W  = 2 * SUM_W + 1;
  localparam int DP_W  = RANGE_W + DIST_SHIFT;
  localparam logic [SUM_W:0]  RA_C    = (SUM_W + 1)'((2 ** SUM_W) / WINDOW_LENGTH);
  localparam logic [CW:0]     MOD_C   = (CW + 1)'(COUNT_MODULUS);
  localparam logic [SUM_W-1:0] WIN_C  = SUM_W'(WINDOW_LENGTH);
  localparam logic [PW-1:0]   POS_END = PW'(WINDOW_LENGTH - 1);

  // Edge detect and pulse width
  logic          prev_r;
  logic [CW-1:0] stamp_r;
  logic          fall3_r;
  logic [CW-1:0] w3_r;
  logic [CW:0]   diff;
  logic [CW-1:0] width_nxt;

  // Width ring and running sum
  logic [CW-1:0]    ring_mem_r [WINDOW_LENGTH];
  logic [SUM_W-1:0] sum_r;
  logic [PW-1:0]    pos_r;
  logic             wrap_r;
  logic [CW-1:0]    old_r;
  logic             fall4_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [PW-1:0]    pos_nxt;
  logic             wrap_nxt;

  // Average and distance
  logic [PR_W-1:0]       prod5_r;
  logic [SUM_W-1:0]      sum5_r;
  logic                  fall5_r;
  logic [CW-1:0]         q0;
  logic [SUM_W-1:0]      rem;
  logic [CW-1:0]         avg6_r;
  logic                  fall6_r;
  logic [SCALE_W+CW-1:0] dprod;
  logic [DP_W-1:0]       dprod_ext;
  logic [RANGE_W-1:0]    dist7_r;
  logic                  fall7_r;

  always_comb begin
    diff      = {1'b0, now_mod} - {1'b0, stamp_r};
    width_nxt = diff[CW] ? CW'(diff + MOD_C) : CW'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      stamp_r <= '0;
      fall3_r <= 1'b0;
    end else if (ld.p3) begin
      fall3_r <= prev_r && !echo_level;
      if (echo_level && !prev_r) begin
        stamp_r <= now_mod;
      end
      prev_r <= echo_level;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.p3) begin
      w3_r <= width_nxt;
    end
  end

  always_comb begin
    sum_nxt  = sum_r - SUM_W'(old_r) + SUM_W'(w3_r);
    pos_nxt  = (pos_r == POS_END) ? '0 : pos_r + 1'b1;
    wrap_nxt = wrap_r || (pos_r == POS_END);
  end

  always_ff @(posedge clk) begin
    if (ld.p4 && fall3_r) begin
      ring_mem_r[pos_r] <= w3_r;
    end
  end

  // old_r always holds the entry about to be replaced; unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      pos_r   <= '0;
      wrap_r  <= 1'b0;
      old_r   <= '0;
      fall4_r <= 1'b0;
    end else if (ld.p4) begin
      fall4_r <= fall3_r;
      if (fall3_r) begin
        sum_r  <= sum_nxt;
        pos_r  <= pos_nxt;
        wrap_r <= wrap_nxt;
        if (pos_nxt == pos_r) begin
          old_r <= w3_r;
        end else if (!wrap_nxt) begin
          old_r <= '0;
        end else begin
          old_r <= ring_mem_r[pos_nxt];
        end
      end
    end
  end

  always_comb begin
    q0        = prod5_r[SUM_W+CW-1:SUM_W];
    rem       = sum5_r - SUM_W'(q0) * WIN_C;
    dprod     = (SCALE_W + CW)'(scale_per_tick) * (SCALE_W + CW)'(avg6_r);
    dprod_ext = DP_W'(dprod);
  end

  always_ff @(posedge clk) begin
    if (ld.p5) begin
      prod5_r <= PR_W'(sum_r) * PR_W'(RA_C);
      sum5_r  <= sum_r;
      fall5_r <= fall4_r;
    end
    if (ld.p6) begin
      avg6_r  <= (rem >= WIN_C) ? q0 + 1'b1 : q0;
      fall6_r <= fall5_r;
    end
    if (ld.p7) begin
      dist7_r <= dprod_ext[DP_W-1:DIST_SHIFT];
      fall7_r <= fall6_r;
    end
  end

  assign meas_valid = fall7_r;
  assign lane_range = dist7_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_END)
    else $error("ring position beyond window");

  a_old_before_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    !wrap_r |-> (old_r == '0))
    else $error("unwritten ring entry read as nonzero");

endmodule

// ===== rtl/ecr_merge.sv =====
module ecr_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  ecr_pkg::pipe_ld_t                               ld,
  input  logic [ecr_pkg::NUM_CH-1:0]                      meas_valid,
  input  logic [ecr_pkg::NUM_CH-1:0][ecr_pkg::RANGE_W-1:0] lane_range,
  input  logic [ecr_pkg::RANGE_W-1:0]                     jump_limit,
  output logic [ecr_pkg::NUM_CH-1:0][ecr_pkg::RANGE_W-1:0] ranges,
  output logic                                            trigger_pulse
);
  import ecr_pkg::*;

  // The head range register is also the accepted head distance.
  logic [NUM_CH-1:0][RANGE_W-1:0] range_r;
  logic [NUM_CH-1:0]              flags_r;
  logic                           trig_r;
  logic [NUM_CH-1:0]              flags_nxt;
  logic                           head_jump;

  always_comb begin
    flags_nxt = flags_r | meas_valid;
    head_jump = {1'b0, lane_range[CH_HEAD]} >
                ({1'b0, range_r[CH_HEAD]} + {1'b0, jump_limit});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= '0;
      flags_r <= '0;
      trig_r  <= 1'b0;
    end else if (ld.p8) begin
      if (meas_valid[CH_HEAD] && !head_jump) begin
        range_r[CH_HEAD] <= lane_range[CH_HEAD];
      end
      if (meas_valid[CH_LEFT]) begin
        range_r[CH_LEFT] <= lane_range[CH_LEFT];
      end
      if (meas_valid[CH_RIGHT]) begin
        range_r[CH_RIGHT] <= lane_range[CH_RIGHT];
      end
      if (&flags_nxt) begin
        flags_r <= '0;
        trig_r  <= 1'b1;
      end else begin
        flags_r <= flags_nxt;
        trig_r  <= 1'b0;
      end
    end
  end

  assign ranges        = range_r;
  assign trigger_pulse = trig_r;

  a_trig_clears: assert property (@(posedge clk) disable iff (!rst_n)
    trig_r |-> (flags_r == '0))
    else $error("trigger given with channel marks still set");

endmodule

// ===== test/tb_three_channel_echo_ranger.sv =====
module tb_three_channel_echo_ranger;
  import ecr_pkg::*;

  // Sum of ten 16-bit widths fits in 20 bits.
  localparam int SUM_W       = 20;
  localparam int WINDOW      = WINDOW_LENGTH_DEF;
  localparam int IDLE_PCT    = 17;
  localparam int STEADY_LO   = 300;
  localparam int STEADY_HI   = 500;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = NUM_STAGES + 4;
  localparam int PHASE_ITEMS = 200;

  // Register indexes with no register behind them; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

  // One result transfer, laid out as out_tdata[69:0].
  typedef struct packed {
    logic               trigger_pulse;
    logic [RANGE_W-1:0] range_right;
    logic [RANGE_W-1:0] range_left;
    logic [RANGE_W-1:0] range_head;
  } ranges_t;

  // Predicts the ranges for each accepted pin event and holds them until the
  // matching result transfer arrives.
  class echo_range_board;
    logic [SCALE_W-1:0] scale;
    logic [RANGE_W-1:0] jump;
    logic [NUM_CH-1:0]  levels;
    logic [TIMER_W-1:0] rise_at [NUM_CH];
    logic [TIMER_W-1:0] widths  [NUM_CH][WINDOW];
    logic [SUM_W-1:0]   sums    [NUM_CH];
    int                 slot    [NUM_CH];
    logic [RANGE_W-1:0] ranges  [NUM_CH];
    logic [RANGE_W-1:0] head_accepted;
    logic [NUM_CH-1:0]  measured;
    ranges_t            pending_ranges [$];
    int                 errors;

    function new();
      scale         = SCALE_RESET;
      jump          = JUMP_RESET;
      levels        = '0;
      head_accepted = '0;
      measured      = '0;
      errors        = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        rise_at[ch] = '0;
        sums[ch]    = '0;
        slot[ch]    = 0;
        ranges[ch]  = '0;
        for (int k = 0; k < WINDOW; k++) widths[ch][k] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCALE_PER_TICK: scale = data[SCALE_W-1:0];
        CFG_JUMP_LIMIT:     jump  = data[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    // Falling edge: push the wrapped width into the window, rescale the mean.
    function void close_pulse(int ch, logic [TIMER_W-1:0] now);
      logic [TIMER_W-1:0] w;
      logic [63:0]        scaled;
      int                 pos;
      pos = slot[ch];
      w   = now - rise_at[ch];
      sums[ch] = sums[ch] - SUM_W'(widths[ch][pos]) + SUM_W'(w);
      widths[ch][pos] = w;
      scaled = (64'(scale) * 64'(sums[ch] / WINDOW)) >> DIST_SHIFT;
      scaled = scaled & ((64'd1 << RANGE_W) - 1);
      // Head only: a jump above the limit keeps the last accepted distance.
      if (ch == CH_HEAD) begin
        if (scaled > 64'(head_accepted) + 64'(jump)) scaled = 64'(head_accepted);
        else head_accepted = scaled[RANGE_W-1:0];
      end
      ranges[ch] = scaled[RANGE_W-1:0];
      slot[ch]   = (pos + 1) % WINDOW;
      measured[ch] = 1'b1;
    endfunction

    function void note_event(logic [NUM_CH-1:0] pins, logic [TIMER_W-1:0] now);
      ranges_t want;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (pins[ch] != levels[ch]) begin
          if (levels[ch]) close_pulse(ch, now);
          else rise_at[ch] = now;
          levels[ch] = pins[ch];
        end
      end
      want.trigger_pulse = &measured;
      if (&measured) measured = '0;
      want.range_head  = ranges[CH_HEAD];
      want.range_left  = ranges[CH_LEFT];
      want.range_right = ranges[CH_RIGHT];
      pending_ranges.push_back(want);
    endfunction

    function void compare_field(string name, logic [RANGE_W-1:0] want, logic [RANGE_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      ranges_t got;
      ranges_t want;
      got = data[$bits(ranges_t)-1:0];
      if (pending_ranges.size() == 0) begin
        errors++;
        $display("%0t: result with no event pending, expected none, actual %h", $time, data);
        return;
      end
      want = pending_ranges.pop_front();
      compare_field("range_head",    want.range_head,    got.range_head);
      compare_field("range_left",    want.range_left,    got.range_left);
      compare_field("range_right",   want.range_right,   got.range_right);
      compare_field("trigger_pulse", RANGE_W'(want.trigger_pulse),
                    RANGE_W'(got.trigger_pulse));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  echo_range_board board;
  logic [NUM_CH-1:0]  pins;          // pin levels as last sent
  logic [TIMER_W-1:0] stamp;         // running timer for random events
  int                 events_sent;   // input transfers, sender's count
  int                 inputs_seen;   // input transfers, receiver's count
  int                 hold_left;
  bit                 held_once;
  int                 quiet_cycles;

  three_channel_echo_ranger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Both sides run without gaps inside this window of input transfers.
  function automatic bit steady_window(int count);
    return count >= STEADY_LO && count < STEADY_HI;
  endfunction

  // Offer one pin event and hold it until the block takes the transfer.
  // Gaps lower tvalid; a back-to-back item keeps it high with new data.
  task automatic send_event(input logic [NUM_CH-1:0] levels, input logic [TIMER_W-1:0] now);
    while (!steady_window(events_sent) && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {{(IN_TDATA_W - TIMER_W - NUM_CH){1'b0}}, now, levels};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_event(levels, now);
    pins = levels;
    events_sent++;
  endtask

  // Drop tvalid, wait for every expected result, then let the pipe empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending_ranges.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Leave cfg_valid high on return; the caller drops it after its last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] scale_val,
                              input logic [CFG_DATA_W-1:0] jump_val);
    settle();
    cfg_write(CFG_SCALE_PER_TICK, scale_val);
    cfg_write(CFG_JUMP_LIMIT, jump_val);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short pulses so that the window mean stays near the jump limit;
  // some events repeat the levels, some jump the timer anywhere.
  task automatic run_random(input int count);
    logic [NUM_CH-1:0] flip;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 12) flip = '0;
      else flip = NUM_CH'($urandom_range(1, 7));
      if ($urandom_range(99) < 25) stamp = TIMER_W'($urandom());
      else stamp = stamp + TIMER_W'($urandom_range(0, 3000));
      send_event(pins ^ flip, stamp);
    end
  endtask

  // Receiver: check each result transfer, stall at random, and hold off once
  // for a long stretch so that the pipe fills and in_tready drops.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (rst_n && in_tvalid && in_tready) inputs_seen <= inputs_seen + 1;
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!held_once && inputs_seen >= HOLD_AT) begin
      held_once  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady_window(inputs_seen) || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    board        = new();
    pins         = '0;
    stamp        = '0;
    events_sent  = 0;
    inputs_seen  = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    quiet_cycles = 0;
    rst_n      <= 1'b0;
    in_tdata   <= '0;
    in_tvalid  <= 1'b0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_SCALE_PER_TICK;
    cfg_data   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events under reset settings; levels are {right, left, head}.
    send_event(3'b000, 16'h0000);   // no edge: ranges still zero
    send_event(3'b001, 16'h0000);   // head rises at the bottom of the count
    send_event(3'b000, 16'hFFFF);   // widest head pulse: first head distance rejected
    send_event(3'b111, 16'd65000);  // all channels rise together
    send_event(3'b111, 16'd65010);  // unchanged levels
    send_event(3'b010, 16'd100);    // head and right fall across the count wrap
    send_event(3'b000, 16'd200);    // left completes the set: trigger
    send_event(3'b000, 16'd300);    // flags cleared, no trigger
    send_event(3'b111, 16'd300);
    send_event(3'b000, 16'd310);    // all fall in one event: trigger at once
    send_event(3'b011, 16'h5555);
    send_event(3'b100, 16'hAAAA);
    send_event(3'b111, 16'hFFFF);
    send_event(3'b000, 16'h0000);   // head and left pulses of one tick across the wrap from the top
    send_event(3'b001, 16'd5);
    send_event(3'b000, 16'd20);     // short head pulse, still rejected: window mean far above the limit
    stamp = 16'd20;

    // Extremes first, then zero, random, masked oversize, small, and back to reset.
    program_regs(23'h00FFFF, 23'h7FFFFF);
    run_random(PHASE_ITEMS);
    program_regs(23'd0, 23'd0);
    run_random(PHASE_ITEMS);
    program_regs(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
    run_random(PHASE_ITEMS / 2);
    settle();                       // sender pause until every result is in
    run_random(PHASE_ITEMS / 2);
    settle();
    cfg_write(CFG_UNMAPPED_LO, CFG_DATA_W'($urandom()));
    cfg_write(CFG_UNMAPPED_HI, CFG_DATA_W'($urandom()));
    cfg_write(CFG_SCALE_PER_TICK, 23'h7FFFFF);   // upper bits must be dropped
    cfg_write(CFG_JUMP_LIMIT, CFG_DATA_W'($urandom_range(0, 3000)));
    cfg_valid <= 1'b0;
    run_random(PHASE_ITEMS);
    program_regs(23'd1, 23'd1);
    run_random(PHASE_ITEMS);
    program_regs(CFG_DATA_W'(SCALE_RESET), CFG_DATA_W'(JUMP_RESET));
    run_random(PHASE_ITEMS);

    settle();
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ecr_pkg.sv
rtl/ecr_front.sv
rtl/ecr_lane.sv
rtl/ecr_merge.sv
rtl/three_channel_echo_ranger.sv
test/tb_three_channel_echo_ranger.sv
